>>> rtl/ets_pkg.sv
// Shared types, constants and lookup functions for the expression token scanner.
`timescale 1ns / 1ps
package ets_pkg;

   localparam int LENGTH_BITS   = 8;
   localparam int POSITION_BITS = 32;
   localparam int KIND_BITS     = 5;
   localparam int CHAR_BITS     = 8;
   localparam int KW_BITS       = 5;

   localparam int RSP_BITS      = KIND_BITS + LENGTH_BITS + POSITION_BITS;
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   // Result queue: two entries must be free before an item is processed.
   localparam int RSP_DEPTH     = 4;
   localparam int RSP_PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS  = $clog2(RSP_DEPTH + 1);

   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0a;
   localparam logic [CHAR_BITS-1:0] CH_DOT     = 8'h2e;
   localparam logic [CHAR_BITS-1:0] CH_LT      = 8'h3c;
   localparam logic [CHAR_BITS-1:0] CH_GT      = 8'h3e;
   localparam logic [CHAR_BITS-1:0] CH_EQ      = 8'h3d;

   // Keyword trie nodes: NONE means no keyword prefix, ROOT is the empty prefix.
   localparam logic [KW_BITS-1:0] KW_NONE = 5'd0;
   localparam logic [KW_BITS-1:0] KW_ROOT = 5'd31;

   typedef enum logic [KIND_BITS-1:0] {
      TOK_NEWLINE = 5'd0,
      TOK_LPAREN  = 5'd1,
      TOK_RPAREN  = 5'd2,
      TOK_ASSIGN  = 5'd3,
      TOK_COMMA   = 5'd4,
      TOK_PLUS    = 5'd5,
      TOK_MINUS   = 5'd6,
      TOK_STAR    = 5'd7,
      TOK_SLASH   = 5'd8,
      TOK_PERCENT = 5'd9,
      TOK_CARET   = 5'd10,
      TOK_IF      = 5'd11,
      TOK_THEN    = 5'd12,
      TOK_ELSE    = 5'd13,
      TOK_OR      = 5'd14,
      TOK_AND     = 5'd15,
      TOK_NOT     = 5'd16,
      TOK_LT      = 5'd17,
      TOK_GT      = 5'd18,
      TOK_LE      = 5'd19,
      TOK_GE      = 5'd20,
      TOK_NE      = 5'd21,
      TOK_IDENT   = 5'd22,
      TOK_INT     = 5'd23,
      TOK_DOUBLE  = 5'd24,
      TOK_EOF     = 5'd25,
      TOK_ERROR   = 5'd26
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_NEWLINE = 3'd1,
      MODE_LT      = 3'd2,
      MODE_GT      = 3'd3,
      MODE_IDENT   = 3'd4,
      MODE_INT     = 3'd5,
      MODE_DEC     = 3'd6
   } mode_type;

   typedef struct packed {
      logic                     last;
      logic [POSITION_BITS-1:0] start;
      logic [LENGTH_BITS-1:0]   length;
      kind_type                 kind;
   } token_type;

   function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   // One step down the keyword trie; falls to KW_NONE when no keyword fits.
   function automatic logic [KW_BITS-1:0] kw_next(input logic [KW_BITS-1:0] from,
                                                  input logic [CHAR_BITS-1:0] c);
      logic [KW_BITS-1:0] nxt;
      nxt = KW_NONE;
      case (from)
         KW_ROOT: begin
            case (c)
               "i":     nxt = 5'd1;
               "t":     nxt = 5'd3;
               "e":     nxt = 5'd7;
               "o":     nxt = 5'd11;
               "a":     nxt = 5'd13;
               "n":     nxt = 5'd16;
               default: nxt = KW_NONE;
            endcase
         end
         5'd1:    nxt = (c == "f") ? 5'd2  : KW_NONE;
         5'd3:    nxt = (c == "h") ? 5'd4  : KW_NONE;
         5'd4:    nxt = (c == "e") ? 5'd5  : KW_NONE;
         5'd5:    nxt = (c == "n") ? 5'd6  : KW_NONE;
         5'd7:    nxt = (c == "l") ? 5'd8  : KW_NONE;
         5'd8:    nxt = (c == "s") ? 5'd9  : KW_NONE;
         5'd9:    nxt = (c == "e") ? 5'd10 : KW_NONE;
         5'd11:   nxt = (c == "r") ? 5'd12 : KW_NONE;
         5'd13:   nxt = (c == "n") ? 5'd14 : KW_NONE;
         5'd14:   nxt = (c == "d") ? 5'd15 : KW_NONE;
         5'd16:   nxt = (c == "o") ? 5'd17 : KW_NONE;
         5'd17:   nxt = (c == "t") ? 5'd18 : KW_NONE;
         default: nxt = KW_NONE;
      endcase
      return nxt;
   endfunction

   // Kind of a finished identifier, given the trie node its text reached.
   function automatic kind_type kw_kind(input logic [KW_BITS-1:0] node);
      kind_type k;
      case (node)
         5'd2:    k = TOK_IF;
         5'd6:    k = TOK_THEN;
         5'd10:   k = TOK_ELSE;
         5'd12:   k = TOK_OR;
         5'd15:   k = TOK_AND;
         5'd18:   k = TOK_NOT;
         default: k = TOK_IDENT;
      endcase
      return k;
   endfunction

   // Single-character operators; hit is low for any other byte.
   function automatic logic op_lookup(input logic [CHAR_BITS-1:0] c, output kind_type k);
      logic hit;
      hit = 1'b1;
      case (c)
         "(":     k = TOK_LPAREN;
         ")":     k = TOK_RPAREN;
         "=":     k = TOK_ASSIGN;
         ",":     k = TOK_COMMA;
         "+":     k = TOK_PLUS;
         "-":     k = TOK_MINUS;
         "*":     k = TOK_STAR;
         "/":     k = TOK_SLASH;
         "%":     k = TOK_PERCENT;
         "^":     k = TOK_CARET;
         default: begin
            k   = TOK_ERROR;
            hit = 1'b0;
         end
      endcase
      return hit;
   endfunction

endpackage

>>> rtl/expression_token_scanner.sv
// Top level of the expression token scanner: character stream in, token stream out.
//
// The block reads one character per req item and reports tokens of a small
// expression language on the rsp channel: kind, text length (saturating) and
// the stream position of the token's first character.  req_tuser high marks
// an end-of-text item: any pending token is flushed and an eof token follows.
// One item yields zero, one or two tokens; rsp_tlast is high on the last token
// an item produced; an item that extends a token, or that starts one or is a
// space while nothing is pending, produces nothing.
// Items pass through an input register and are classified from it, and the
// tokens go into a four-entry result queue that drives rsp.  An item is
// processed whenever the queue has two free entries, so req takes one item
// per cycle while the consumer keeps up; a sustained stream of items that
// each yield two tokens is held back by the single rsp port draining the
// queue.
// When rsp_tready is low the queue fills and req_tready drops once the
// registered item cannot be processed.  Synchronous reset empties the queue,
// drops the registered item and returns the scanner to idle at position zero.
`timescale 1ns / 1ps
module expression_token_scanner
   import ets_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [CHAR_BITS-1:0]     req_tdata,   // char_code
   input  logic                     req_tuser,   // end_of_input
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // token_kind, token_length, start_position
   output logic                     rsp_tlast    // last_of_run
);

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0] char_ff;
   logic                 eoi_ff;

   // Scanner state.
   mode_type                 mode_ff, mode_in;
   logic [KW_BITS-1:0]       kp_ff, kp_in;
   logic [LENGTH_BITS-1:0]   plen_ff, plen_in;
   logic [POSITION_BITS-1:0] pstart_ff, pstart_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   // Result queue.
   token_type               queue_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in;

   logic      req_accept;
   logic      rsp_accept;
   logic      process;
   logic      used;
   logic      op_hit;
   kind_type  op_kind;
   token_type pend_tok;
   token_type f_tok, c_tok;
   logic      f_valid, c_valid;
   logic [1:0] push_cnt;
   logic [LENGTH_BITS-1:0] plen_grow;

   // An item is classified only when the queue can take both of its tokens.
   assign process    = in_valid_ff && (count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));
   assign req_tready = !in_valid_ff || process;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   assign in_valid_in = req_accept ? 1'b1 : (process ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         char_ff <= req_tdata;
         eoi_ff  <= req_tuser;
      end
   end

   // The token that a flush would emit for the current scan state.
   always_comb begin
      pend_tok.last   = 1'b0;
      pend_tok.start  = pstart_ff;
      pend_tok.length = plen_ff;
      case (mode_ff)
         MODE_NEWLINE: pend_tok.kind = TOK_NEWLINE;
         MODE_LT:      pend_tok.kind = TOK_LT;
         MODE_GT:      pend_tok.kind = TOK_GT;
         MODE_IDENT:   pend_tok.kind = kw_kind(kp_ff);
         MODE_INT:     pend_tok.kind = TOK_INT;
         default:      pend_tok.kind = TOK_DOUBLE;
      endcase
   end

   assign plen_grow = (plen_ff == '1) ? plen_ff : plen_ff + LENGTH_BITS'(1);

   // Classification: f_tok is a flushed pending token, c_tok the token that
   // the character itself produces (or eof).  f_tok always comes first.
   always_comb begin
      mode_in   = mode_ff;
      kp_in     = kp_ff;
      plen_in   = plen_ff;
      pstart_in = pstart_ff;
      pos_in    = pos_ff;
      used      = 1'b0;
      f_valid   = 1'b0;
      f_tok     = pend_tok;
      c_valid   = 1'b0;
      c_tok     = '{last: 1'b1, start: pos_ff, length: '0, kind: TOK_EOF};
      op_hit    = op_lookup(char_ff, op_kind);

      if (process) begin
         if (eoi_ff) begin
            // End of text: flush, then eof at the current position.
            f_valid = (mode_ff != MODE_IDLE);
            mode_in = MODE_IDLE;
            kp_in   = KW_NONE;
            plen_in = '0;
            c_valid = 1'b1;
         end else begin
            case (mode_ff)
               MODE_NEWLINE: begin
                  used = (char_ff == CH_NEWLINE);
               end
               MODE_LT, MODE_GT: begin
                  if ((char_ff == CH_EQ) || ((mode_ff == MODE_LT) && (char_ff == CH_GT))) begin
                     used         = 1'b1;
                     c_valid      = 1'b1;
                     c_tok.start  = pstart_ff;
                     c_tok.length = LENGTH_BITS'(2);
                     if (mode_ff == MODE_GT) begin
                        c_tok.kind = TOK_GE;
                     end else if (char_ff == CH_EQ) begin
                        c_tok.kind = TOK_LE;
                     end else begin
                        c_tok.kind = TOK_NE;
                     end
                     mode_in = MODE_IDLE;
                     plen_in = '0;
                  end
               end
               MODE_IDENT: begin
                  if (is_alpha(char_ff) || is_digit(char_ff)) begin
                     used    = 1'b1;
                     kp_in   = kw_next(kp_ff, char_ff);
                     plen_in = plen_grow;
                  end
               end
               MODE_INT: begin
                  if (is_digit(char_ff) || (char_ff == CH_DOT)) begin
                     used    = 1'b1;
                     plen_in = plen_grow;
                     if (char_ff == CH_DOT) begin
                        mode_in = MODE_DEC;
                     end
                  end
               end
               MODE_DEC: begin
                  if (is_digit(char_ff)) begin
                     used    = 1'b1;
                     plen_in = plen_grow;
                  end
               end
               default: begin
                  used = 1'b0;
               end
            endcase

            if (!used) begin
               // The character ends whatever was pending and starts afresh.
               f_valid = (mode_ff != MODE_IDLE);
               mode_in = MODE_IDLE;
               kp_in   = KW_NONE;
               plen_in = '0;
               if (char_ff == CH_SPACE) begin
                  mode_in = MODE_IDLE;
               end else if (char_ff == CH_NEWLINE) begin
                  mode_in   = MODE_NEWLINE;
                  pstart_in = pos_ff;
               end else if (op_hit) begin
                  c_valid      = 1'b1;
                  c_tok.kind   = op_kind;
                  c_tok.length = LENGTH_BITS'(1);
               end else if ((char_ff == CH_LT) || (char_ff == CH_GT) ||
                            is_alpha(char_ff) || is_digit(char_ff)) begin
                  if (char_ff == CH_LT) begin
                     mode_in = MODE_LT;
                  end else if (char_ff == CH_GT) begin
                     mode_in = MODE_GT;
                  end else if (is_alpha(char_ff)) begin
                     mode_in = MODE_IDENT;
                     kp_in   = kw_next(KW_ROOT, char_ff);
                  end else begin
                     mode_in = MODE_INT;
                  end
                  pstart_in = pos_ff;
                  plen_in   = LENGTH_BITS'(1);
               end else begin
                  c_valid      = 1'b1;
                  c_tok.kind   = TOK_ERROR;
                  c_tok.length = LENGTH_BITS'(1);
               end
            end
            pos_in = pos_ff + POSITION_BITS'(1);
         end
      end
      f_tok.last = !c_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         kp_ff     <= KW_NONE;
         plen_ff   <= '0;
         pstart_ff <= '0;
         pos_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         kp_ff     <= kp_in;
         plen_ff   <= plen_in;
         pstart_ff <= pstart_in;
         pos_ff    <= pos_in;
      end
   end

   // Result queue bookkeeping.
   assign push_cnt  = {1'b0, f_valid} + {1'b0, c_valid};
   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_BITS'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_BITS'(rsp_accept);
   assign count_in  = count_ff + RSP_CNT_BITS'(push_cnt) - RSP_CNT_BITS'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (f_valid) begin
         queue_ff[wr_ptr_ff] <= f_tok;
      end
      if (c_valid) begin
         queue_ff[wr_ptr_ff + RSP_PTR_BITS'(f_valid)] <= c_tok;
      end
   end

   assign rsp_tdata = RSP_DATA_BITS'({queue_ff[rd_ptr_ff].start,
                                      queue_ff[rd_ptr_ff].length,
                                      queue_ff[rd_ptr_ff].kind});
   assign rsp_tlast = queue_ff[rd_ptr_ff].last;

   // The queue never holds more tokens than it has entries.
   assert property (@(posedge clock) disable iff (reset)
                    count_ff <= RSP_CNT_BITS'(RSP_DEPTH))
      else $error("result queue overflow");

   // End of text always produces a token and leaves the scanner idle.
   assert property (@(posedge clock) disable iff (reset)
                    (process && eoi_ff) |-> (c_valid && (mode_in == MODE_IDLE)))
      else $error("end of text did not emit eof");

   // Keyword progress is only tracked inside an identifier.
   assert property (@(posedge clock) disable iff (reset)
                    (mode_ff != MODE_IDENT) |-> (kp_ff == KW_NONE))
      else $error("keyword progress outside identifier");

   // A pending token with text always has a nonzero length.
   assert property (@(posedge clock) disable iff (reset)
                    ((mode_ff != MODE_IDLE) && (mode_ff != MODE_NEWLINE)) |-> (plen_ff != '0))
      else $error("pending token without length");

endmodule
